// File: hdl/jdc_pkg.sv
// ============================================================================
// jdc_pkg - shared types, constants and tables of the Julian day converter
// Result records, operation codes and the small month tables used by the
// date-to-day-number and day-number-to-date pipelines.
// ============================================================================
package jdc_pkg;

    // register stages from input to output register, output register included
    localparam int NUM_STAGES = 10;

    typedef enum logic {
        OP_TO_JDN  = 1'b0,
        OP_TO_DATE = 1'b1
    } op_t;

    // date -> day number result
    typedef struct packed {
        logic [22:0] jdn;
        logic        ok;
    } enc_res_t;

    // day number -> date result
    typedef struct packed {
        logic [4:0]         day;
        logic [3:0]         month;
        logic signed [15:0] year;
    } dec_res_t;

    // Gregorian month length
    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        case (month) inside
            4'd2:                    d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

    // floor(367 * (month - 2 + 12 * adj) / 12), March-based month offset
    function automatic logic [8:0] month_offset(input logic [3:0] month);
        logic [8:0] v;
        case (month)
            4'd1:    v = 9'd336;
            4'd2:    v = 9'd367;
            4'd3:    v = 9'd30;
            4'd4:    v = 9'd61;
            4'd5:    v = 9'd91;
            4'd6:    v = 9'd122;
            4'd7:    v = 9'd152;
            4'd8:    v = 9'd183;
            4'd9:    v = 9'd214;
            4'd10:   v = 9'd244;
            4'd11:   v = 9'd275;
            4'd12:   v = 9'd305;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // floor(2447 * j / 80) for the decoded March-based month index
    function automatic logic [8:0] kday_offset(input logic [3:0] j);
        logic [8:0] v;
        case (j)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd152;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd305;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/jdc_encode.sv
// ============================================================================
// jdc_encode - date to Julian day number pipeline
// Checks the date and evaluates the integer formula over five stages, then
// delays the result to line up with the decode pipeline.
// ============================================================================
module jdc_encode (
    input  logic                              clk,
    input  logic [jdc_pkg::NUM_STAGES-1:0]    en,
    input  logic [4:0]                        day,
    input  logic [3:0]                        month,
    input  logic [13:0]                       year,
    output jdc_pkg::enc_res_t                 res
);

    localparam int ENC_LAST = jdc_pkg::NUM_STAGES - 2;

    // x / 100 by reciprocal, exact for x < 2^15
    localparam int                       S100 = 22;
    localparam longint unsigned          D100 = 100;
    localparam logic [15:0]              M100 =
        16'(((64'd1 << S100) + D100 - 64'd1) / D100);

    // stage 0
    logic [4:0]  d_reg  [0:3];
    logic [3:0]  m_reg  [0:2];
    logic [13:0] y_reg  [0:2];
    logic        ok_reg [0:2];
    logic [14:0] yy_reg, yy_next;
    logic [14:0] z_reg, z_next;
    logic        ok_next;
    logic        adj;

    // stage 1
    logic [25:0] pa_reg, pa_next;
    logic [30:0] pz_reg, pz_next;
    logic [29:0] py_reg, py_next;

    // stage 2
    logic [23:0] a_reg, a_next;
    logic [8:0]  qz_reg, qz_next;
    logic [1:0]  q100lo_reg, q100lo_next;
    logic [14:0] t100_reg, t100_next;
    logic [7:0]  q100;

    // stage 3
    logic [22:0] s_reg, s_next;
    logic        okf_reg, okf_next;
    logic        leap;
    logic [4:0]  days;
    logic [9:0]  c;

    // stage 4 and delay line
    logic [22:0] jdn_reg [4:ENC_LAST];
    logic        okd_reg [4:ENC_LAST];
    logic [22:0] jdn_next;
    logic [22:0] r;

    always_comb
    begin
        adj     = (month <= 4'd2);
        yy_next = 15'(year) + 15'd4800 - 15'(adj);
        z_next  = 15'(year) + 15'd4900 - 15'(adj);
        ok_next = (month >= 4'd1) && (month <= 4'd12) && (year > 14'd1752) && (day != 5'd0);
    end

    always_comb
    begin
        pa_next = 26'(yy_reg) * 26'd1461;
        pz_next = 31'(z_reg) * 31'(M100);
        py_next = 30'(y_reg[0]) * 30'(M100);
    end

    always_comb
    begin
        a_next      = 24'(pa_reg >> 2);
        qz_next     = pz_reg[30:22];
        q100        = py_reg[29:22];
        q100lo_next = q100[1:0];
        t100_next   = 15'(q100) * 15'd100;
    end

    always_comb
    begin
        // divisible by 100: leap when the century count is a multiple of 4
        leap     = (15'(y_reg[2]) == t100_reg) ? (q100lo_reg == 2'd0)
                                               : (y_reg[2][1:0] == 2'd0);
        days     = jdc_pkg::month_days(m_reg[2], leap);
        c        = 10'((11'(qz_reg) * 11'd3) >> 2);
        s_next   = 23'(a_reg) + 23'(jdc_pkg::month_offset(m_reg[2])) - 23'(c);
        okf_next = ok_reg[2] && (d_reg[2] <= days);
    end

    always_comb
    begin
        r        = s_reg + 23'(d_reg[3]) - 23'd32075;
        jdn_next = okf_reg ? r : 23'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_reg[0]  <= day;
            m_reg[0]  <= month;
            y_reg[0]  <= year;
            ok_reg[0] <= ok_next;
            yy_reg    <= yy_next;
            z_reg     <= z_next;
        end
        if (en[1])
        begin
            d_reg[1]  <= d_reg[0];
            m_reg[1]  <= m_reg[0];
            y_reg[1]  <= y_reg[0];
            ok_reg[1] <= ok_reg[0];
            pa_reg    <= pa_next;
            pz_reg    <= pz_next;
            py_reg    <= py_next;
        end
        if (en[2])
        begin
            d_reg[2]   <= d_reg[1];
            m_reg[2]   <= m_reg[1];
            y_reg[2]   <= y_reg[1];
            ok_reg[2]  <= ok_reg[1];
            a_reg      <= a_next;
            qz_reg     <= qz_next;
            q100lo_reg <= q100lo_next;
            t100_reg   <= t100_next;
        end
        if (en[3])
        begin
            d_reg[3] <= d_reg[2];
            s_reg    <= s_next;
            okf_reg  <= okf_next;
        end
        if (en[4])
        begin
            jdn_reg[4] <= jdn_next;
            okd_reg[4] <= okf_reg;
        end
        for (int k = 5; k <= ENC_LAST; k++)
        begin
            if (en[k])
            begin
                jdn_reg[k] <= jdn_reg[k-1];
                okd_reg[k] <= okd_reg[k-1];
            end
        end
    end

    assign res.jdn = jdn_reg[ENC_LAST];
    assign res.ok  = okd_reg[ENC_LAST];

endmodule

// File: hdl/jdc_decode.sv
// ============================================================================
// jdc_decode - Julian day number to date pipeline
// Nine register stages; every constant division is an exact reciprocal
// multiply, each product registered before it is used.
// ============================================================================
module jdc_decode (
    input  logic                              clk,
    input  logic [jdc_pkg::NUM_STAGES-1:0]    en,
    input  logic [22:0]                       julian_day,
    output jdc_pkg::dec_res_t                 res
);

    // floor(4L / 146097): x = 4L < 2^26, divisor < 2^18
    localparam int              S1 = 44;
    localparam longint unsigned D1 = 146097;
    localparam logic [26:0]     M1 = 27'(((64'd1 << S1) + D1 - 64'd1) / D1);

    // floor(a / 1461001): a < 2^28, divisor < 2^21
    localparam int              S2 = 49;
    localparam longint unsigned D2 = 1461001;
    localparam logic [28:0]     M2 = 29'(((64'd1 << S2) + D2 - 64'd1) / D2);

    // floor(80 L3 / 2447): 80 L3 < 2^17, divisor < 2^12; the 80 folds in
    localparam int              S3 = 29;
    localparam longint unsigned D3 = 2447;
    localparam logic [24:0]     K3 = 25'((((64'd1 << S3) + D3 - 64'd1) / D3) * 64'd80);

    logic [23:0] l_reg [0:2];
    logic [23:0] l_next;
    logic [50:0] pn_reg, pn_next;
    logic [7:0]  n_reg, n_next;
    logic [25:0] t_reg, t_next;
    logic [15:0] l2_reg [3:6];
    logic [15:0] l2_next;
    logic [14:0] nh_reg [3:6];
    logic [14:0] nh_next;
    logic [27:0] a_reg, a_next;
    logic [56:0] pi_reg, pi_next;
    logic [7:0]  i_reg, i_next;
    logic [18:0] h_reg, h_next;
    logic [9:0]  l3_reg [7:8];
    logic [9:0]  l3_next;
    logic [15:0] yb_reg [7:8];
    logic [15:0] yb_next;
    logic [34:0] pj_reg, pj_next;
    logic [3:0]  j;
    logic        l4;

    always_comb
    begin
        l_next  = 24'(julian_day) + 24'd68569;
        pn_next = 51'(l_reg[0]) * 51'(M1);
        n_next  = pn_reg[49:42];
        t_next  = 26'(n_next) * 26'd146097;
        l2_next = 16'(l_reg[2] - 24'((t_reg + 26'd3) >> 2));
        nh_next = 15'(n_reg) * 15'd100;
        a_next  = (28'(l2_reg[3]) + 28'd1) * 28'd4000;
        pi_next = 57'(a_reg) * 57'(M2);
        i_next  = pi_reg[56:49];
        h_next  = 19'(i_next) * 19'd1461;
        l3_next = 10'(l2_reg[6] - 16'(h_reg >> 2) + 16'd31);
        yb_next = 16'(nh_reg[6]) - 16'd4900 + 16'(i_reg);
        pj_next = 35'(l3_reg[7]) * 35'(K3);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            l_reg[0] <= l_next;
        if (en[1])
        begin
            l_reg[1] <= l_reg[0];
            pn_reg   <= pn_next;
        end
        if (en[2])
        begin
            l_reg[2] <= l_reg[1];
            n_reg    <= n_next;
            t_reg    <= t_next;
        end
        if (en[3])
        begin
            l2_reg[3] <= l2_next;
            nh_reg[3] <= nh_next;
        end
        if (en[4])
        begin
            l2_reg[4] <= l2_reg[3];
            nh_reg[4] <= nh_reg[3];
            a_reg     <= a_next;
        end
        if (en[5])
        begin
            l2_reg[5] <= l2_reg[4];
            nh_reg[5] <= nh_reg[4];
            pi_reg    <= pi_next;
        end
        if (en[6])
        begin
            l2_reg[6] <= l2_reg[5];
            nh_reg[6] <= nh_reg[5];
            i_reg     <= i_next;
            h_reg     <= h_next;
        end
        if (en[7])
        begin
            l3_reg[7] <= l3_next;
            yb_reg[7] <= yb_next;
        end
        if (en[8])
        begin
            l3_reg[8] <= l3_reg[7];
            yb_reg[8] <= yb_reg[7];
            pj_reg    <= pj_next;
        end
    end

    // last step feeds the output register in the top level
    always_comb
    begin
        j         = pj_reg[32:29];
        l4        = (j >= 4'd11);
        res.day   = 5'(l3_reg[8] - 10'(jdc_pkg::kday_offset(j)));
        res.month = l4 ? (j - 4'd10) : (j + 4'd2);
        res.year  = yb_reg[8] + 16'(l4);
    end

endmodule

// File: hdl/julian_day_converter_top.sv
// ============================================================================
// julian_day_converter_top - Gregorian date <-> Julian day number converter
// Stream in, stream out; one result word for every request word.
// ============================================================================
//
// Usage:
//   s_* channel takes request words. s_tuser selects the operation:
//   0 turns day/month/year into a day number (the date is range checked,
//   a rejected date returns an all-zero word with m_tuser low), 1 turns a
//   day number into day/month/year (m_tuser always high).
//   m_* channel returns the result words in request order.
//
//   Depth: ten register stages; the accepting edge loads the first one,
//   and m_tvalid rises once the word reaches the last. The depth is set
//   by the day-number-to-date chain of three reciprocal multiplies, the
//   first two each followed by a registered back-multiply, the last by a
//   table lookup. Throughput: one word per cycle while m_tready is high.
//
//   Every stage has its own valid bit and a load enable that is high when
//   the stage is empty or the next stage moves, so bubbles squeeze out when
//   m_tready is low; s_tready falls only once all ten stages hold words.
//   Reset clears the valid bits only: nothing is in flight afterward.
//
module julian_day_converter_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // day_in[4:0], month_in[8:5], year_in[22:9],
                                   // julian_day_in[45:23], zero [47:46]
    input  logic        s_tuser,   // operation

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // julian_day_out[22:0], day_out[27:23],
                                   // month_out[31:28], year_out[47:32]
    output logic        m_tuser    // valid_res
);

    localparam int NS = jdc_pkg::NUM_STAGES;

    logic [NS-1:0]       v_reg, v_next;
    logic [NS-1:0]       en;
    jdc_pkg::op_t        op_reg [0:NS-1];

    jdc_pkg::enc_res_t   enc_res;
    jdc_pkg::dec_res_t   dec_res;

    // output register
    logic [22:0]         jdn_reg, jdn_next;
    logic [4:0]          day_reg, day_next;
    logic [3:0]          month_reg, month_next;
    logic signed [15:0]  year_reg, year_next;
    logic                vres_reg, vres_next;

    // stage enables, from the output back to the input
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign s_tready = en[0];

    always_comb
    begin
        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < NS; k++)
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    // operation travels with its word
    always_ff @(posedge clk)
    begin
        if (en[0])
            op_reg[0] <= jdc_pkg::op_t'(s_tuser);
        for (int k = 1; k < NS; k++)
            if (en[k])
                op_reg[k] <= op_reg[k-1];
    end

    jdc_encode u_encode (
        .clk   (clk),
        .en    (en),
        .day   (s_tdata[4:0]),
        .month (s_tdata[8:5]),
        .year  (s_tdata[22:9]),
        .res   (enc_res)
    );

    jdc_decode u_decode (
        .clk        (clk),
        .en         (en),
        .julian_day (s_tdata[45:23]),
        .res        (dec_res)
    );

    // pick the finished operation; unused fields read zero
    always_comb
    begin
        if (op_reg[NS-2] == jdc_pkg::OP_TO_DATE)
        begin
            jdn_next   = 23'd0;
            day_next   = dec_res.day;
            month_next = dec_res.month;
            year_next  = dec_res.year;
            vres_next  = 1'b1;
        end
        else
        begin
            jdn_next   = enc_res.jdn;
            day_next   = 5'd0;
            month_next = 4'd0;
            year_next  = 16'sd0;
            vres_next  = enc_res.ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            jdn_reg   <= jdn_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            vres_reg  <= vres_next;
        end
    end

    assign m_tvalid = v_reg[NS-1];
    assign m_tdata  = {year_reg, month_reg, day_reg, jdn_reg};
    assign m_tuser  = vres_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // input backs up only when every stage is full and the output is stalled
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("s_tready low with room in the pipeline");

    // an accepted word occupies the first stage next cycle
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v_reg[0])
        else $error("accepted word lost at the first stage");

    // a rejected date gives an all-zero word
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 48'd0))
        else $error("rejected date with nonzero result");

    // a decoded date is always flagged valid and has a real month
    a_date_month: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (op_reg[NS-1] == jdc_pkg::OP_TO_DATE))
            |-> (m_tuser && (month_reg >= 4'd1) && (month_reg <= 4'd12)))
        else $error("decoded month out of range");

endmodule
